// ----- design/pmbe_pkg.sv -----
// ----------------------------------------------------------------------------
// pmbe_pkg
// Types and constants shared by the POP3 mail body extractor.
// ----------------------------------------------------------------------------
package pmbe_pkg;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINK_HDR_LEN = 1'b0,
    REG_SERVER_PORT  = 1'b1
  } cfg_reg_t;

  localparam logic [6:0]  LINK_HDR_LEN_RST = 7'd14;
  localparam logic [15:0] SERVER_PORT_RST  = 16'd110;

  localparam logic [7:0]  TCP_PROTO = 8'd6;
  localparam logic [5:0]  HDR_BYTES = 6'd40;
  localparam logic [2:0]  LEN_POS   = 3'd4;
  localparam logic [7:0]  CHAR_ZERO = 8'h30;
  localparam logic [7:0]  CHAR_NINE = 8'h39;

  // header byte positions, counted from the start of the IP header
  localparam logic [5:0] H_IPLEN_HI = 6'd2;
  localparam logic [5:0] H_IPLEN_LO = 6'd3;
  localparam logic [5:0] H_PROTO    = 6'd9;
  localparam logic [5:0] H_SPORT_HI = 6'd20;
  localparam logic [5:0] H_SPORT_LO = 6'd21;
  localparam logic [5:0] H_FLAGS    = 6'd33;
  localparam logic [5:0] H_LAST     = 6'd39;

  typedef enum logic [4:0] {
    PH_WAIT   = 5'b00001,
    PH_DIGITS = 5'b00010,
    PH_SKIP   = 5'b00100,
    PH_BODY   = 5'b01000,
    PH_REJECT = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_first;
    logic       frame_last;
  } pmbe_in_t;

  typedef struct packed {
    logic [7:0]  body_byte;
    logic        byte_valid;
    logic        mail_done;
    logic [15:0] mail_number;
    logic [31:0] announced_length;
  } pmbe_out_t;

  typedef struct packed {
    logic [6:0]  link_header_length;
    logic [15:0] server_port;
  } pmbe_cfg_t;

  // length * 10 + digit, saturating at 32 bits
  function automatic logic [31:0] dec_accum(input logic [31:0] v, input logic [3:0] d);
    logic [35:0] s;
    s = 36'({v, 3'b000}) + 36'({v, 1'b0}) + 36'(d);
    return (s[35:32] != 4'd0) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- design/pop3_mail_body_extractor.sv -----
// ----------------------------------------------------------------------------
// pop3_mail_body_extractor
// Pulls mail body bytes out of captured POP3 server frames.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle and returns at most one result per byte:
// the byte is held in the input register, then the parser step writes the
// result register. A held result stalls the parser step, which
// in turn stalls the input once the input register is full; otherwise a new
// byte is taken every cycle. Only bytes that are emitted or that close a mail
// produce a result. Configuration is written through cfg_we/cfg_index/
// cfg_wdata and should only change while no item is in flight.
module pop3_mail_body_extractor import pmbe_pkg::*; #(
  parameter int OFFSET_WIDTH = 16,
  parameter int INDEX_WIDTH  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pmbe_in_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pmbe_out_t              out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  pmbe_cfg_t cfg_r;
  logic      in_valid_r;
  pmbe_in_t  in_item_r;
  logic      out_valid_r;
  pmbe_out_t out_item_r;
  logic      adv;
  logic      res_valid;
  pmbe_out_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.link_header_length <= LINK_HDR_LEN_RST;
      cfg_r.server_port        <= SERVER_PORT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LINK_HDR_LEN: cfg_r.link_header_length <= cfg_wdata[6:0];
        REG_SERVER_PORT:  cfg_r.server_port        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parser step runs when the input register holds a byte and the result register can take its output
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_item;
  end

  pmbe_core #(
    .OFFSET_WIDTH(OFFSET_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .item     (in_item_r),
    .cfg      (cfg_r),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.byte_valid || out_item.mail_done))
    else $error("result carries neither a byte nor a close");

  a_body_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.byte_valid) |-> (out_item.body_byte == 8'd0))
    else $error("body byte not zero on a close-only result");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a held result");

  a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && out_valid_r) |-> !out_stall)
    else $error("parser stepped over a held result");

endmodule

// ----- design/pmbe_core.sv -----
// ----------------------------------------------------------------------------
// pmbe_core
// Per-byte frame parser and mail tracker: header capture, segment
// qualification, length parse and body emit. State advances on step.
// ----------------------------------------------------------------------------
module pmbe_core import pmbe_pkg::*; #(
  parameter int OFFSET_WIDTH = 16,
  parameter int INDEX_WIDTH  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  pmbe_in_t  item,
  input  pmbe_cfg_t cfg,
  output logic      res_valid,
  output pmbe_out_t res
);

  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;

  logic [OFFSET_WIDTH-1:0] frame_offset_r, frame_offset_nxt;
  logic [15:0]             ip_length_r, ip_length_nxt;
  logic                    segment_ok_r, segment_ok_nxt;
  logic [15:0]             sport_r, sport_nxt;
  logic [7:0]              proto_r, proto_nxt;
  logic [1:0]              flags_r, flags_nxt;
  logic                    receiving_r, receiving_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [31:0]             mail_length_r, mail_length_nxt;
  logic [31:0]             mail_count_r, mail_count_nxt;
  logic [INDEX_WIDTH-1:0]  mail_index_r, mail_index_nxt;

  logic [OFFSET_WIDTH-1:0] off, h, p;
  logic [15:0]             plen;
  logic [32:0]             p_ext, plen_ext;
  logic                    digit, emit, ended, done;
  logic [31:0]             idx_ext;

  assign plen = (ip_length_r > 16'(HDR_BYTES)) ? (ip_length_r - 16'(HDR_BYTES)) : 16'd0;
  assign digit = item.frame_byte inside {[CHAR_ZERO:CHAR_NINE]};

  always_comb begin
    frame_offset_nxt = frame_offset_r;
    ip_length_nxt    = ip_length_r;
    segment_ok_nxt   = segment_ok_r;
    sport_nxt        = sport_r;
    proto_nxt        = proto_r;
    flags_nxt        = flags_r;
    receiving_nxt    = receiving_r;
    phase_nxt        = phase_r;
    mail_length_nxt  = mail_length_r;
    mail_count_nxt   = mail_count_r;
    mail_index_nxt   = mail_index_r;
    emit  = 1'b0;
    ended = 1'b0;
    done  = 1'b0;
    off   = frame_offset_r;
    h     = '0;
    p     = '0;
    p_ext    = '0;
    plen_ext = 33'(plen);

    if (item.frame_first) begin
      off            = '0;
      segment_ok_nxt = 1'b0;
    end

    if (off != OFF_MAX) begin
      if (off >= OFFSET_WIDTH'(cfg.link_header_length)) begin
        h = off - OFFSET_WIDTH'(cfg.link_header_length);
        if (h < OFFSET_WIDTH'(HDR_BYTES)) begin
          case (h[5:0])
            H_IPLEN_HI: ip_length_nxt = {item.frame_byte, ip_length_r[7:0]};
            H_IPLEN_LO: ip_length_nxt = {ip_length_r[15:8], item.frame_byte};
            H_PROTO:    proto_nxt = item.frame_byte;
            H_SPORT_HI: sport_nxt = {item.frame_byte, sport_r[7:0]};
            H_SPORT_LO: sport_nxt = {sport_r[15:8], item.frame_byte};
            H_FLAGS:    flags_nxt = item.frame_byte[1:0];
            H_LAST: begin
              segment_ok_nxt = (proto_r == TCP_PROTO) && (sport_r == cfg.server_port) &&
                               (flags_r == 2'b00);
              if (segment_ok_nxt) begin
                phase_nxt = PH_WAIT;
                if (plen == 16'd0) ended = 1'b1;
              end
            end
            default: ;
          endcase
        end else if (segment_ok_nxt) begin
          p     = h - OFFSET_WIDTH'(HDR_BYTES);
          p_ext = 33'(p);
          if (p_ext < plen_ext) begin
            if (receiving_r) begin
              emit = 1'b1;
            end else begin
              case (phase_r)
                PH_WAIT: begin
                  if (p == OFFSET_WIDTH'(LEN_POS)) begin
                    if (digit) begin
                      phase_nxt       = PH_DIGITS;
                      mail_length_nxt = 32'(item.frame_byte[3:0]);
                      mail_count_nxt  = '0;
                    end else begin
                      phase_nxt = PH_REJECT;
                    end
                  end
                end
                PH_DIGITS: begin
                  if (digit) mail_length_nxt = dec_accum(mail_length_r, item.frame_byte[3:0]);
                  else       phase_nxt = PH_SKIP;
                end
                PH_SKIP: phase_nxt = PH_BODY;
                PH_BODY: emit = 1'b1;
                default: ;
              endcase
            end
            if (emit && (mail_count_nxt != 32'hFFFF_FFFF))
              mail_count_nxt = mail_count_nxt + 32'd1;
            if ((p_ext + 33'd1) >= plen_ext || item.frame_last) ended = 1'b1;
          end else begin
            segment_ok_nxt = 1'b0;
          end
        end
      end
      frame_offset_nxt = off + OFFSET_WIDTH'(1);
    end else begin
      frame_offset_nxt = off;
    end

    if (ended) begin
      segment_ok_nxt = 1'b0;
      if (receiving_r) begin
        if (mail_count_nxt >= mail_length_nxt) begin
          receiving_nxt = 1'b0;
          done          = 1'b1;
        end
      end else if (phase_nxt == PH_DIGITS || phase_nxt == PH_SKIP || phase_nxt == PH_BODY) begin
        receiving_nxt = 1'b1;
      end
      if (done) mail_index_nxt = mail_index_r + INDEX_WIDTH'(1);
    end

    if (item.frame_last) begin
      frame_offset_nxt = OFF_MAX;
      segment_ok_nxt   = 1'b0;
    end
  end

  // mail number is the index before this item's close
  assign idx_ext   = 32'(mail_index_r);
  assign res_valid = emit || done;
  assign res.body_byte        = emit ? item.frame_byte : 8'd0;
  assign res.byte_valid       = emit;
  assign res.mail_done        = done;
  assign res.mail_number      = idx_ext[15:0];
  assign res.announced_length = mail_length_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_offset_r <= '0;
      ip_length_r    <= '0;
      segment_ok_r   <= 1'b0;
      sport_r        <= '0;
      proto_r        <= '0;
      flags_r        <= '0;
      receiving_r    <= 1'b0;
      phase_r        <= PH_WAIT;
      mail_length_r  <= '0;
      mail_count_r   <= '0;
      mail_index_r   <= '0;
    end else if (step) begin
      frame_offset_r <= frame_offset_nxt;
      ip_length_r    <= ip_length_nxt;
      segment_ok_r   <= segment_ok_nxt;
      sport_r        <= sport_nxt;
      proto_r        <= proto_nxt;
      flags_r        <= flags_nxt;
      receiving_r    <= receiving_nxt;
      phase_r        <= phase_nxt;
      mail_length_r  <= mail_length_nxt;
      mail_count_r   <= mail_count_nxt;
      mail_index_r   <= mail_index_nxt;
    end
  end

endmodule
